[src/msts_pkg.sv]
// Shared types and constants for the multi-stream timestamp synchroniser.
// Used by the top, front and back modules (not by msts_fifo); depends on nothing.
package msts_pkg;

  localparam int STREAM_W = 4;
  localparam int TS_W     = 64;
  localparam int TAG_W    = 32;
  localparam int THR_W    = 31;
  // out_stream, out_timestamp_us, out_tag, last
  localparam int RES_W    = STREAM_W + TS_W + TAG_W + 1;

  localparam int MS_DIVISOR = 1000;

  // register indexes of the configuration port
  localparam logic [1:0] REG_ACTIVE_STREAMS = 2'd0;
  localparam logic [1:0] REG_QUEUE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_SYNC_THRESHOLD = 2'd2;

  localparam logic [4:0]  RST_ACTIVE_STREAMS = 5'd4;
  localparam logic [3:0]  RST_QUEUE_LIMIT    = 4'd8;
  // (50 ms + 1) * 1000 us
  localparam logic [30:0] RST_THR_US         = 31'd51000;

  // thr_us holds (sync_threshold_ms + 1) * 1000: a head is too old when
  // latest - head >= thr_us, which is the same as (latest - head) / 1000 > ms
  typedef struct packed {
    logic [4:0]       active_streams;
    logic [3:0]       queue_limit;
    logic [THR_W-1:0] thr_us;
  } cfg_t;

endpackage

[src/multi_stream_timestamp_sync.sv]
// The front queue feeds frames to the back-end sequencer, which takes one only when idle,
// stores it in its ring unless the limit is zero and, if every active stream then holds a
// frame, scans the ring heads in the frame store three times: for the latest timestamp, to
// drop one head that is too old (ending the attempt), then to emit one result per stream.
// Reset (rst, synchronous): ring pointers and fill counts cleared, registers to defaults;
// the frame store is not cleared and no clearing pass runs.
module multi_stream_timestamp_sync #(
  parameter int NUM_STREAMS = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [19:0]                   cfg_data,
  // input words
  input  logic                          push,
  output logic                          full,
  input  logic [msts_pkg::STREAM_W-1:0] stream_index,
  input  logic [msts_pkg::TS_W-1:0]     timestamp_us,
  input  logic [msts_pkg::TAG_W-1:0]    frame_tag,
  // result words
  output logic                          empty,
  input  logic                          pop,
  output logic [msts_pkg::STREAM_W-1:0] out_stream,
  output logic [msts_pkg::TS_W-1:0]     out_timestamp_us,
  output logic [msts_pkg::TAG_W-1:0]    out_tag,
  output logic                          last
);

  localparam int SI_W  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int CMD_W = SI_W + msts_pkg::TS_W + msts_pkg::TAG_W;

  msts_pkg::cfg_t   cfg;
  logic             cmd_pop;
  logic             cmd_empty;
  logic [CMD_W-1:0] cmd_data;

  // configuration registers; threshold kept in microseconds, plus one ms
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_streams <= msts_pkg::RST_ACTIVE_STREAMS;
      cfg.queue_limit    <= msts_pkg::RST_QUEUE_LIMIT;
      cfg.thr_us         <= msts_pkg::RST_THR_US;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msts_pkg::REG_ACTIVE_STREAMS: cfg.active_streams <= cfg_data[4:0];
        msts_pkg::REG_QUEUE_LIMIT:    cfg.queue_limit    <= cfg_data[3:0];
        msts_pkg::REG_SYNC_THRESHOLD:
          cfg.thr_us <= msts_pkg::THR_W'((msts_pkg::THR_W'(cfg_data)
                        + msts_pkg::THR_W'(1))
                        * msts_pkg::THR_W'(msts_pkg::MS_DIVISOR));
        default: ;
      endcase
    end
  end

  msts_front #(
    .NUM_STREAMS(NUM_STREAMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .stream_index(stream_index),
    .timestamp_us(timestamp_us),
    .frame_tag   (frame_tag),
    .cmd_pop     (cmd_pop),
    .cmd_empty   (cmd_empty),
    .cmd_data    (cmd_data)
  );

  msts_back #(
    .NUM_STREAMS(NUM_STREAMS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd_empty       (cmd_empty),
    .cmd_data        (cmd_data),
    .cmd_pop         (cmd_pop),
    .out_stream      (out_stream),
    .out_timestamp_us(out_timestamp_us),
    .out_tag         (out_tag),
    .last            (last),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

[src/msts_fifo.sv]
// Small flop-based queue, used between front and back and for results.
// Depends on nothing.
module msts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  // pointer wrap at DEPTH
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == DEPTH - 1) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= bump(wptr);
      if (do_pop) rptr <= bump(rptr);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

[src/msts_front.sv]
// Front end: takes input words, drops those for streams outside the active
// set and queues the rest for the back end. Depends on msts_pkg, msts_fifo.
module msts_front #(
  parameter int NUM_STREAMS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  msts_pkg::cfg_t               cfg,
  input  logic                         push,
  output logic                         full,
  input  logic [msts_pkg::STREAM_W-1:0] stream_index,
  input  logic [msts_pkg::TS_W-1:0]    timestamp_us,
  input  logic [msts_pkg::TAG_W-1:0]   frame_tag,
  input  logic                         cmd_pop,
  output logic                         cmd_empty,
  output logic [((NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1)
                + msts_pkg::TS_W + msts_pkg::TAG_W - 1:0] cmd_data
);

  localparam int SI_W  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int N_W   = $clog2(NUM_STREAMS + 1);
  localparam int CMD_W = SI_W + msts_pkg::TS_W + msts_pkg::TAG_W;

  logic [N_W-1:0]   n_eff;
  logic             in_range;
  logic             q_full;
  logic             q_push;
  logic [CMD_W-1:0] q_wdata;

  // effective stream count, clamped to the built size
  always_comb begin
    if (32'(cfg.active_streams) > NUM_STREAMS) n_eff = N_W'(NUM_STREAMS);
    else n_eff = N_W'(cfg.active_streams);
  end

  // classify: words for unknown streams are taken and discarded
  assign in_range = 32'(stream_index) < 32'(n_eff);
  assign full     = q_full;
  assign q_push   = push && !q_full && in_range;
  assign q_wdata  = {SI_W'(stream_index), timestamp_us, frame_tag};

  msts_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(cmd_data),
    .empty(cmd_empty)
  );

endmodule

[src/msts_back.sv]
// Back end: per-stream ring buffers in one frame store, the sync sequencer and
// the result queue. Depends on msts_pkg and msts_fifo.
module msts_back #(
  parameter int NUM_STREAMS = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msts_pkg::cfg_t                cfg,
  input  logic                          cmd_empty,
  input  logic [((NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1)
                + msts_pkg::TS_W + msts_pkg::TAG_W - 1:0] cmd_data,
  output logic                          cmd_pop,
  output logic [msts_pkg::STREAM_W-1:0] out_stream,
  output logic [msts_pkg::TS_W-1:0]     out_timestamp_us,
  output logic [msts_pkg::TAG_W-1:0]    out_tag,
  output logic                          last,
  output logic                          empty,
  input  logic                          pop
);

  localparam int SI_W   = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int N_W    = $clog2(NUM_STREAMS + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int MEM_D  = NUM_STREAMS * QUEUE_DEPTH;
  localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int TS_W   = msts_pkg::TS_W;
  localparam int TAG_W  = msts_pkg::TAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_CHECK, S_MAX_RD, S_MAX_USE,
    S_AGE_RD, S_AGE_USE, S_EMIT_RD, S_EMIT_USE
  } state_t;

  state_t            state;
  logic [SI_W-1:0]   s_q;
  logic [TS_W-1:0]   ts_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SI_W-1:0]   idx;
  logic [TS_W-1:0]   latest;
  logic [PTR_W-1:0]  head [NUM_STREAMS];
  logic [CNT_W-1:0]  fill [NUM_STREAMS];

  logic [TS_W-1:0]   ts_mem  [MEM_D];
  logic [TAG_W-1:0]  tag_mem [MEM_D];
  logic [TS_W-1:0]   rd_ts;
  logic [TAG_W-1:0]  rd_tag;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;

  logic [N_W-1:0]    n_eff;
  logic [CNT_W-1:0]  lim;
  logic [PTR_W-1:0]  upd_head;
  logic [CNT_W-1:0]  upd_fill;
  logic [PTR_W-1:0]  wr_ptr;
  logic              all_ok;
  logic              is_last;
  logic [TS_W-1:0]   diff;
  logic              too_old;
  logic              res_push;
  logic              res_full;
  logic [msts_pkg::RES_W-1:0] res_wdata;
  logic [msts_pkg::RES_W-1:0] res_rdata;

  // ring pointer wrap, valid for values below twice the depth
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] x);
    logic [PTR_W-1:0] r;
    if (x >= SUM_W'(QUEUE_DEPTH)) r = PTR_W'(x - SUM_W'(QUEUE_DEPTH));
    else r = PTR_W'(x);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [SI_W-1:0] s,
                                             input logic [PTR_W-1:0] p);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
  endfunction

  // effective configuration
  always_comb begin
    if (32'(cfg.active_streams) > NUM_STREAMS) n_eff = N_W'(NUM_STREAMS);
    else n_eff = N_W'(cfg.active_streams);
    if (32'(cfg.queue_limit) > QUEUE_DEPTH) lim = CNT_W'(QUEUE_DEPTH);
    else lim = CNT_W'(cfg.queue_limit);
  end

  // push into the ring of stream s_q: trim to the limit, keep room for one
  always_comb begin
    logic [PTR_W-1:0] h;
    logic [CNT_W-1:0] c;
    h = head[s_q];
    c = fill[s_q];
    if (c > lim) begin
      h = wrap_ptr(SUM_W'(h) + SUM_W'(c - lim));
      c = lim;
    end
    if (c == lim) begin
      h = wrap_ptr(SUM_W'(h) + SUM_W'(1));
      c = c - CNT_W'(1);
    end
    wr_ptr   = wrap_ptr(SUM_W'(h) + SUM_W'(c));
    upd_head = h;
    upd_fill = c + CNT_W'(1);
  end

  // every active stream holds a frame
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (i < 32'(n_eff) && fill[i] == '0) all_ok = 1'b0;
    end
  end

  assign is_last  = (N_W'(idx) + N_W'(1)) == n_eff;
  assign diff     = latest - rd_ts;
  assign too_old  = diff >= TS_W'(cfg.thr_us);
  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign mem_we   = (state == S_UPD) && (lim != '0);
  assign wr_addr  = slot(s_q, wr_ptr);
  assign rd_addr  = slot(idx, head[idx]);
  assign res_push = (state == S_EMIT_USE) && !res_full;
  assign res_wdata = {msts_pkg::STREAM_W'(idx), rd_ts, rd_tag, is_last};

  // frame store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ts_mem[wr_addr]  <= ts_q;
      tag_mem[wr_addr] <= tag_q;
    end
    rd_ts  <= ts_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

  // sequencer: update, check, max scan, age scan, emit scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            {s_q, ts_q, tag_q} <= cmd_data;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (lim == '0) begin
            head[s_q] <= '0;
            fill[s_q] <= '0;
          end else begin
            head[s_q] <= upd_head;
            fill[s_q] <= upd_fill;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          idx    <= '0;
          latest <= '0;
          state  <= all_ok ? S_MAX_RD : S_IDLE;
        end
        S_MAX_RD: state <= S_MAX_USE;
        S_MAX_USE: begin
          if (rd_ts > latest) latest <= rd_ts;
          if (is_last) begin
            idx   <= '0;
            state <= S_AGE_RD;
          end else begin
            idx   <= idx + SI_W'(1);
            state <= S_MAX_RD;
          end
        end
        S_AGE_RD: state <= S_AGE_USE;
        S_AGE_USE: begin
          if (too_old) begin
            head[idx] <= wrap_ptr(SUM_W'(head[idx]) + SUM_W'(1));
            fill[idx] <= fill[idx] - CNT_W'(1);
            state     <= S_IDLE;
          end else if (is_last) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx + SI_W'(1);
            state <= S_AGE_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_USE;
        S_EMIT_USE: begin
          if (!res_full) begin
            head[idx] <= wrap_ptr(SUM_W'(head[idx]) + SUM_W'(1));
            fill[idx] <= fill[idx] - CNT_W'(1);
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + SI_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result queue
  msts_fifo #(
    .WIDTH(msts_pkg::RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_wdata),
    .full (res_full),
    .pop  (pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign {out_stream, out_timestamp_us, out_tag, last} = res_rdata;

`ifndef SYNTH
  // a scan only starts when every active ring holds a frame
  a_scan_needs_frames: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAX_RD) |-> all_ok)
    else $error("head scan started with an empty active ring");

  // the last word of a set ends the sequence
  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    (res_push && is_last) |=> (state == S_IDLE))
    else $error("sequencer kept going after the last word of a set");

  // a push with a non-zero limit leaves the ring occupied
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && lim != '0) |=> (fill[$past(s_q)] != '0))
    else $error("ring empty after a push");
`endif

endmodule
